/* rtl/sknr_pkg.sv */
// Shared types and codes for the send-key nonce and rekey guard.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sknr_pkg;

    localparam int TickWidth    = 64;
    localparam int AgeWidth     = 32;
    localparam int ApbAddrWidth = 6;
    localparam int ApbDataWidth = 64;

    // Request kinds
    localparam logic [1:0] REQ_PACKET    = 2'd0;
    localparam logic [1:0] REQ_INSTALL   = 2'd1;
    localparam logic [1:0] REQ_HANDSHAKE = 2'd2;
    localparam logic [1:0] REQ_RESP_SENT = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NO_KEY      = 3'd1;
    localparam logic [2:0] ST_INVALID     = 3'd2;
    localparam logic [2:0] ST_TOO_OLD     = 3'd3;
    localparam logic [2:0] ST_NONCE_LIMIT = 3'd4;

    // Register indexes, one 8-byte slot each
    localparam logic [2:0] REG_REJECT_MSG = 3'd0;
    localparam logic [2:0] REG_REKEY_MSG  = 3'd1;
    localparam logic [2:0] REG_REJECT_AGE = 3'd2;
    localparam logic [2:0] REG_REKEY_AGE  = 3'd3;
    localparam logic [2:0] REG_HS_GAP     = 3'd4;

    // Register reset values
    localparam logic [63:0] RST_REJECT_MSG = 64'h1000_0000_0000_0000;
    localparam logic [63:0] RST_REKEY_MSG  = 64'h1000_0000_0000_0000;
    localparam logic [31:0] RST_REJECT_AGE = 32'd180000;
    localparam logic [31:0] RST_REKEY_AGE  = 32'd120000;
    localparam logic [31:0] RST_HS_GAP     = 32'd5000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] now_ticks;
        logic        install_as_initiator;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] nonce_out;
        logic        start_handshake;
        logic        key_usable;
    } rsp_t;

    typedef struct packed {
        logic [63:0] reject_message_limit;
        logic [63:0] rekey_message_limit;
        logic [31:0] reject_age_ticks;
        logic [31:0] rekey_age_ticks;
        logic [31:0] handshake_gap_ticks;
    } cfg_t;

endpackage

/* rtl/sknr_cfg.sv */
// APB register file for the guard limits and ages.
// Depends on sknr_pkg for cfg_t, register indexes and reset values.
`timescale 1ns / 1ps

module sknr_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sknr_pkg::ApbAddrWidth-1:0]   paddr,
    input  logic [sknr_pkg::ApbDataWidth-1:0]   pwdata,
    output logic [sknr_pkg::ApbDataWidth-1:0]   prdata,
    output logic                                pready,
    output sknr_pkg::cfg_t                      cfg
);

    sknr_pkg::cfg_t cfg_reg;
    logic [2:0]     reg_index;
    logic           wr_en;

    // Registers sit on 8-byte boundaries
    assign reg_index = paddr[5:3];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reject_message_limit <= sknr_pkg::RST_REJECT_MSG;
            cfg_reg.rekey_message_limit  <= sknr_pkg::RST_REKEY_MSG;
            cfg_reg.reject_age_ticks     <= sknr_pkg::RST_REJECT_AGE;
            cfg_reg.rekey_age_ticks      <= sknr_pkg::RST_REKEY_AGE;
            cfg_reg.handshake_gap_ticks  <= sknr_pkg::RST_HS_GAP;
        end
        else if (wr_en)
        begin
            case (reg_index)
                sknr_pkg::REG_REJECT_MSG: cfg_reg.reject_message_limit <= pwdata;
                sknr_pkg::REG_REKEY_MSG:  cfg_reg.rekey_message_limit  <= pwdata;
                sknr_pkg::REG_REJECT_AGE: cfg_reg.reject_age_ticks     <= pwdata[31:0];
                sknr_pkg::REG_REKEY_AGE:  cfg_reg.rekey_age_ticks      <= pwdata[31:0];
                sknr_pkg::REG_HS_GAP:     cfg_reg.handshake_gap_ticks  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            sknr_pkg::REG_REJECT_MSG: prdata = cfg_reg.reject_message_limit;
            sknr_pkg::REG_REKEY_MSG:  prdata = cfg_reg.rekey_message_limit;
            sknr_pkg::REG_REJECT_AGE: prdata = {32'd0, cfg_reg.reject_age_ticks};
            sknr_pkg::REG_REKEY_AGE:  prdata = {32'd0, cfg_reg.rekey_age_ticks};
            sknr_pkg::REG_HS_GAP:     prdata = {32'd0, cfg_reg.handshake_gap_ticks};
            default:                  prdata = '0;
        endcase
    end

endmodule

/* rtl/sknr_core.sv */
// Key state and single-pass evaluation of one request word.
// Depends on sknr_pkg for req_t, rsp_t, cfg_t and the status codes.
`timescale 1ns / 1ps

module sknr_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  sknr_pkg::req_t req,
    input  sknr_pkg::cfg_t cfg,
    output sknr_pkg::rsp_t rsp
);

    logic [63:0] counter_reg, counter_next;
    logic [63:0] birth_reg, birth_next;
    logic        valid_reg, valid_next;
    logic        present_reg, present_next;
    logic        initiator_reg, initiator_next;
    logic [63:0] last_hs_reg, last_hs_next;
    logic        hs_sent_reg, hs_sent_next;

    logic [63:0] key_age;
    logic [63:0] hs_age;
    logic [63:0] counter_inc;
    logic        too_old;
    logic        rekey_old;
    logic        gap_ok;
    logic [2:0]  status;
    logic [63:0] nonce;
    logic        start;

    assign key_age     = req.now_ticks - birth_reg;
    assign hs_age      = req.now_ticks - last_hs_reg;
    assign counter_inc = counter_reg + 64'd1;
    assign too_old     = key_age >= {32'd0, cfg.reject_age_ticks};
    assign rekey_old   = key_age >= {32'd0, cfg.rekey_age_ticks};
    assign gap_ok      = !hs_sent_reg || (hs_age > {32'd0, cfg.handshake_gap_ticks});

    always_comb
    begin
        counter_next   = counter_reg;
        birth_next     = birth_reg;
        valid_next     = valid_reg;
        present_next   = present_reg;
        initiator_next = initiator_reg;
        last_hs_next   = last_hs_reg;
        hs_sent_next   = hs_sent_reg;
        status         = sknr_pkg::ST_OK;
        nonce          = '0;
        start          = 1'b0;

        case (req.req_type)
            sknr_pkg::REQ_PACKET:
            begin
                if (!present_reg)
                begin
                    status = sknr_pkg::ST_NO_KEY;
                    start  = gap_ok;
                end
                else if (!valid_reg)
                begin
                    status = sknr_pkg::ST_INVALID;
                end
                else if (too_old)
                begin
                    valid_next = 1'b0;
                    status     = sknr_pkg::ST_TOO_OLD;
                end
                else
                begin
                    // counter advances even when the nonce is refused
                    counter_next = counter_inc;
                    if (counter_reg >= cfg.reject_message_limit)
                    begin
                        valid_next = 1'b0;
                        status     = sknr_pkg::ST_NONCE_LIMIT;
                    end
                    else
                    begin
                        nonce = counter_reg;
                        if ((counter_inc > cfg.rekey_message_limit) ||
                            (initiator_reg && rekey_old))
                        begin
                            start = gap_ok;
                        end
                    end
                end
            end
            sknr_pkg::REQ_INSTALL:
            begin
                counter_next   = '0;
                birth_next     = req.now_ticks;
                valid_next     = 1'b1;
                present_next   = 1'b1;
                initiator_next = req.install_as_initiator;
            end
            sknr_pkg::REQ_HANDSHAKE:
            begin
                start = gap_ok;
            end
            sknr_pkg::REQ_RESP_SENT:
            begin
                last_hs_next = req.now_ticks;
                hs_sent_next = 1'b1;
            end
            default: ;
        endcase

        // stamp an issued initiation
        if (start)
        begin
            last_hs_next = req.now_ticks;
            hs_sent_next = 1'b1;
        end
    end

    assign rsp.status          = status;
    assign rsp.nonce_out       = nonce;
    assign rsp.start_handshake = start;
    assign rsp.key_usable      = valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= '0;
            birth_reg     <= '0;
            valid_reg     <= 1'b0;
            present_reg   <= 1'b0;
            initiator_reg <= 1'b0;
            last_hs_reg   <= '0;
            hs_sent_reg   <= 1'b0;
        end
        else if (step)
        begin
            counter_reg   <= counter_next;
            birth_reg     <= birth_next;
            valid_reg     <= valid_next;
            present_reg   <= present_next;
            initiator_reg <= initiator_next;
            last_hs_reg   <= last_hs_next;
            hs_sent_reg   <= hs_sent_next;
        end
    end

endmodule

/* rtl/send_key_nonce_and_rekey_guard_core.sv */
// Top level of the send-key nonce and rekey guard: input and result registers.
// Depends on sknr_pkg, sknr_cfg and sknr_core.
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+----------------------
//   req     | in        | req_valid / req_stall | sknr_pkg::req_t
//   rsp     | out       | rsp_valid / rsp_stall | sknr_pkg::rsp_t
//   apb     | in        | psel / penable        | 64-bit register data
//
// One word per cycle sustained while rsp_stall stays low; each accepted request
// word passes the input register, then the result register, to its result word.
// The key state updates as the word moves from the input register to the
// result register, so consecutive words see each other's effect.
// A stalled result register holds and backs up into req_stall at once.
// Reset clears the key state and loads the register defaults.
`timescale 1ns / 1ps

module send_key_nonce_and_rekey_guard_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  sknr_pkg::req_t                      req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output sknr_pkg::rsp_t                      rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sknr_pkg::ApbAddrWidth-1:0]   paddr,
    input  logic [sknr_pkg::ApbDataWidth-1:0]   pwdata,
    output logic [sknr_pkg::ApbDataWidth-1:0]   prdata,
    output logic                                pready
);

    sknr_pkg::cfg_t cfg;
    sknr_pkg::req_t req_reg;
    sknr_pkg::rsp_t rsp_reg;
    sknr_pkg::rsp_t rsp_next;
    logic           req_valid_reg;
    logic           rsp_valid_reg;
    logic           advance;
    logic           req_take;

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign req_stall = req_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    sknr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sknr_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (req_valid_reg && advance),
        .req   (req_reg),
        .cfg   (cfg),
        .rsp   (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                rsp_valid_reg <= req_valid_reg;
            end
            if (req_take)
            begin
                req_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                req_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg <= req;
        end
        if (advance && req_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/sknr_checker.sv */
// Port-level checks for the send-key guard, bound to the top level.
// Depends on sknr_pkg for rsp_t and the status codes.
`timescale 1ns / 1ps

module sknr_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input sknr_pkg::rsp_t rsp
);

    // stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result word changed under stall");

    // refused packets carry no nonce
    a_nonce_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != sknr_pkg::ST_OK) |-> (rsp.nonce_out == 64'd0))
        else $error("nonce on a refused packet");

    // any refusal leaves the key unusable
    a_refuse_unusable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != sknr_pkg::ST_OK) |-> !rsp.key_usable)
        else $error("key usable after refusal");

    // initiations only come with ok or no-key results
    a_start_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.start_handshake |->
            (rsp.status == sknr_pkg::ST_OK) || (rsp.status == sknr_pkg::ST_NO_KEY))
        else $error("initiation with refused packet");

endmodule

bind send_key_nonce_and_rekey_guard_core sknr_checker u_sknr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

/* sim/send_key_nonce_and_rekey_guard_core_tb.sv */
// Self-checking testbench for send_key_nonce_and_rekey_guard_core.
// Directed table, then random request words checked against a local key-guard predictor.
// Depends on sknr_pkg and the RTL of the block.
`timescale 1ns / 1ps

module send_key_nonce_and_rekey_guard_core_tb;

    // index past the last register; writes there are dropped
    localparam logic [2:0] REG_UNMAPPED = 3'd5;

    typedef struct
    {
        sknr_pkg::req_t word;
        bit             typed;
        sknr_pkg::rsp_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    sknr_pkg::req_t req;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    sknr_pkg::rsp_t rsp;
    logic psel;
    logic penable;
    logic pwrite;
    logic [sknr_pkg::ApbAddrWidth-1:0] paddr;
    logic [sknr_pkg::ApbDataWidth-1:0] pwdata;
    logic [sknr_pkg::ApbDataWidth-1:0] prdata;
    logic pready;

    // key guard state as the block should hold it
    logic [63:0] ctr_q;
    logic [63:0] birth_q;
    logic        valid_q;
    logic        present_q;
    logic        initiator_q;
    logic [63:0] last_hs_q;
    logic        hs_sent_q;
    logic [63:0] reject_msg_q;
    logic [63:0] rekey_msg_q;
    logic [31:0] reject_age_q;
    logic [31:0] rekey_age_q;
    logic [31:0] hs_gap_q;

    sknr_pkg::rsp_t expected_q[$];
    stim_row_t      table_q[$];
    int             errors = 0;
    int             results_seen = 0;
    int             hold_left = 0;
    bit             calm;
    logic [63:0]    wall_ticks;

    send_key_nonce_and_rekey_guard_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic open_handshake(input logic [63:0] now);
        if (hs_sent_q && (now - last_hs_q) <= {32'd0, hs_gap_q})
            return 1'b0;
        last_hs_q = now;
        hs_sent_q = 1'b1;
        return 1'b1;
    endfunction

    function automatic sknr_pkg::rsp_t guard_step(input sknr_pkg::req_t w);
        sknr_pkg::rsp_t r;
        logic [63:0]    age;
        logic [63:0]    n;
        r = '0;
        r.status = sknr_pkg::ST_OK;
        age = w.now_ticks - birth_q;
        case (w.req_type)
            sknr_pkg::REQ_PACKET:
            begin
                if (!present_q)
                begin
                    r.status = sknr_pkg::ST_NO_KEY;
                    r.start_handshake = open_handshake(w.now_ticks);
                end
                else if (!valid_q)
                    r.status = sknr_pkg::ST_INVALID;
                else if (age >= {32'd0, reject_age_q})
                begin
                    valid_q = 1'b0;
                    r.status = sknr_pkg::ST_TOO_OLD;
                end
                else
                begin
                    n = ctr_q;
                    ctr_q = n + 64'd1;
                    if (n >= reject_msg_q)
                    begin
                        valid_q = 1'b0;
                        r.status = sknr_pkg::ST_NONCE_LIMIT;
                    end
                    else
                    begin
                        r.nonce_out = n;
                        if (ctr_q > rekey_msg_q ||
                            (initiator_q && age >= {32'd0, rekey_age_q}))
                            r.start_handshake = open_handshake(w.now_ticks);
                    end
                end
            end
            sknr_pkg::REQ_INSTALL:
            begin
                ctr_q = '0;
                birth_q = w.now_ticks;
                valid_q = 1'b1;
                present_q = 1'b1;
                initiator_q = w.install_as_initiator;
            end
            sknr_pkg::REQ_HANDSHAKE:
                r.start_handshake = open_handshake(w.now_ticks);
            sknr_pkg::REQ_RESP_SENT:
            begin
                last_hs_q = w.now_ticks;
                hs_sent_q = 1'b1;
            end
            default: ;
        endcase
        r.key_usable = valid_q;
        return r;
    endfunction

    task automatic note_failure(input string msg);
        errors++;
        if (errors <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    // receiver: stall for a randomly drawn hold after every accepted word, none while calm
    always @(negedge clk)
    begin
        rsp_stall <= (hold_left > 0);
    end

    always @(posedge clk)
    begin
        sknr_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_seen++;
            hold_left <= calm ? 0 : $urandom_range(0, 13);
            if (expected_q.size() == 0)
                note_failure($sformatf("result %0d arrived with nothing expected: %p",
                                       results_seen, rsp));
            else
            begin
                want = expected_q.pop_front();
                if (rsp.status !== want.status || rsp.nonce_out !== want.nonce_out ||
                    rsp.start_handshake !== want.start_handshake ||
                    rsp.key_usable !== want.key_usable)
                    note_failure($sformatf({"result %0d mismatch: expected status %0d ",
                                            "nonce %h hs %b usable %b, got status %0d ",
                                            "nonce %h hs %b usable %b"},
                                           results_seen, want.status, want.nonce_out,
                                           want.start_handshake, want.key_usable,
                                           rsp.status, rsp.nonce_out,
                                           rsp.start_handshake, rsp.key_usable));
            end
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    task automatic send_word(input sknr_pkg::req_t w, input bit typed,
                             input sknr_pkg::rsp_t want);
        int             gap;
        sknr_pkg::req_t junk;
        sknr_pkg::rsp_t predicted;
        gap = calm ? 0 : $urandom_range(0, 13);
        repeat (gap)
        begin
            @(negedge clk);
            junk.req_type = 2'($urandom);
            junk.now_ticks = {$urandom, $urandom};
            junk.install_as_initiator = 1'($urandom);
            req_valid = 1'b0;
            req = junk;
        end
        @(negedge clk);
        req_valid = 1'b1;
        req = w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = guard_step(w);
        expected_q.push_back(typed ? want : predicted);
    endtask

    // drop valid and hold until every expected word is back
    task automatic drain();
        @(negedge clk);
        req_valid = 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [63:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        case (idx)
            sknr_pkg::REG_REJECT_MSG: reject_msg_q = value;
            sknr_pkg::REG_REKEY_MSG:  rekey_msg_q = value;
            sknr_pkg::REG_REJECT_AGE: reject_age_q = value[31:0];
            sknr_pkg::REG_REKEY_AGE:  rekey_age_q = value[31:0];
            sknr_pkg::REG_HS_GAP:     hs_gap_q = value[31:0];
            default: ;
        endcase
    endtask

    task automatic add_row(input logic [1:0] kind, input logic [63:0] now,
                           input logic init, input bit typed, input logic [2:0] st,
                           input logic [63:0] nonce, input logic hs, input logic usable);
        stim_row_t row;
        row.word.req_type = kind;
        row.word.now_ticks = now;
        row.word.install_as_initiator = init;
        row.typed = typed;
        row.want.status = st;
        row.want.nonce_out = nonce;
        row.want.start_handshake = hs;
        row.want.key_usable = usable;
        table_q.push_back(row);
    endtask

    task automatic run_random(input int count, input int unsigned scale);
        sknr_pkg::req_t w;
        int             roll;
        for (int i = 0; i < count; i++)
        begin
            if (i % 25 == 0)
                calm = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 3)
                wall_ticks = {$urandom, $urandom};
            else if (roll < 5)
                wall_ticks = wall_ticks - $urandom_range(1, scale);
            else
                wall_ticks = wall_ticks + $urandom_range(0, scale);
            roll = $urandom_range(0, 99);
            w.req_type = roll < 72 ? sknr_pkg::REQ_PACKET :
                         roll < 80 ? sknr_pkg::REQ_INSTALL :
                         roll < 90 ? sknr_pkg::REQ_HANDSHAKE : sknr_pkg::REQ_RESP_SENT;
            w.now_ticks = wall_ticks;
            w.install_as_initiator = 1'($urandom_range(0, 1));
            send_word(w, 1'b0, '0);
            if ($urandom_range(0, 39) == 0)
                drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        wall_ticks = '0;
        ctr_q = '0;
        birth_q = '0;
        valid_q = 1'b0;
        present_q = 1'b0;
        initiator_q = 1'b0;
        last_hs_q = '0;
        hs_sent_q = 1'b0;
        reject_msg_q = sknr_pkg::RST_REJECT_MSG;
        rekey_msg_q = sknr_pkg::RST_REKEY_MSG;
        reject_age_q = sknr_pkg::RST_REJECT_AGE;
        rekey_age_q = sknr_pkg::RST_REKEY_AGE;
        hs_gap_q = sknr_pkg::RST_HS_GAP;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // defaults after reset: no key, first handshake free, then rate limit
        add_row(sknr_pkg::REQ_PACKET, 64'd0, 1'b0, 1'b1,
                sknr_pkg::ST_NO_KEY, 64'd0, 1'b1, 1'b0);
        add_row(sknr_pkg::REQ_PACKET, 64'd100, 1'b0, 1'b1,
                sknr_pkg::ST_NO_KEY, 64'd0, 1'b0, 1'b0);
        add_row(sknr_pkg::REQ_HANDSHAKE, 64'd5001, 1'b0, 1'b1,
                sknr_pkg::ST_OK, 64'd0, 1'b1, 1'b0);
        add_row(sknr_pkg::REQ_RESP_SENT, 64'd6000, 1'b1, 1'b1,
                sknr_pkg::ST_OK, 64'd0, 1'b0, 1'b0);
        add_row(sknr_pkg::REQ_INSTALL, 64'd10000, 1'b1, 1'b1,
                sknr_pkg::ST_OK, 64'd0, 1'b0, 1'b1);
        add_row(sknr_pkg::REQ_PACKET, 64'd10000, 1'b0, 1'b1,
                sknr_pkg::ST_OK, 64'd0, 1'b0, 1'b1);
        add_row(sknr_pkg::REQ_PACKET, 64'd10001, 1'b0, 1'b1,
                sknr_pkg::ST_OK, 64'd1, 1'b0, 1'b1);
        // initiator key reaches rekey age
        add_row(sknr_pkg::REQ_PACKET, 64'd130000, 1'b0, 1'b1,
                sknr_pkg::ST_OK, 64'd2, 1'b1, 1'b1);
        add_row(sknr_pkg::REQ_PACKET, 64'd130001, 1'b0, 1'b1,
                sknr_pkg::ST_OK, 64'd3, 1'b0, 1'b1);
        // reject age reached, then the key stays invalid
        add_row(sknr_pkg::REQ_PACKET, 64'd190000, 1'b0, 1'b1,
                sknr_pkg::ST_TOO_OLD, 64'd0, 1'b0, 1'b0);
        add_row(sknr_pkg::REQ_PACKET, 64'd190001, 1'b0, 1'b1,
                sknr_pkg::ST_INVALID, 64'd0, 1'b0, 1'b0);
        add_row(sknr_pkg::REQ_INSTALL, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0, 1'b1,
                sknr_pkg::ST_OK, 64'd0, 1'b0, 1'b1);
        add_row(sknr_pkg::REQ_PACKET, '1, 1'b0, 1'b1,
                sknr_pkg::ST_OK, 64'd0, 1'b0, 1'b1);
        // time runs backward: age wraps and counts as expired
        add_row(sknr_pkg::REQ_PACKET, 64'hFFFF_FFFF_FFFF_FFE0, 1'b0, 1'b1,
                sknr_pkg::ST_TOO_OLD, 64'd0, 1'b0, 1'b0);
        add_row(sknr_pkg::REQ_HANDSHAKE, '1, 1'b0, 1'b1,
                sknr_pkg::ST_OK, 64'd0, 1'b1, 1'b0);
        add_row(sknr_pkg::REQ_HANDSHAKE, 64'd0, 1'b0, 1'b1,
                sknr_pkg::ST_OK, 64'd0, 1'b0, 1'b0);
        add_row(sknr_pkg::REQ_INSTALL, 64'd0, 1'b1, 1'b1,
                sknr_pkg::ST_OK, 64'd0, 1'b0, 1'b1);
        add_row(sknr_pkg::REQ_PACKET, 64'd0, 1'b0, 1'b1,
                sknr_pkg::ST_OK, 64'd0, 1'b0, 1'b1);
        add_row(sknr_pkg::REQ_RESP_SENT, '1, 1'b1, 1'b1,
                sknr_pkg::ST_OK, 64'd0, 1'b0, 1'b1);
        add_row(sknr_pkg::REQ_PACKET, 64'd120000, 1'b0, 1'b0,
                sknr_pkg::ST_OK, 64'd0, 1'b0, 1'b0);
        // gap boundary: equal to the gap is refused, one more is allowed
        add_row(sknr_pkg::REQ_HANDSHAKE, 64'd125000, 1'b0, 1'b0,
                sknr_pkg::ST_OK, 64'd0, 1'b0, 1'b0);
        add_row(sknr_pkg::REQ_HANDSHAKE, 64'd125001, 1'b0, 1'b0,
                sknr_pkg::ST_OK, 64'd0, 1'b0, 1'b0);
        add_row(sknr_pkg::REQ_PACKET, 64'h5555_5555_5555_5555, 1'b1, 1'b0,
                sknr_pkg::ST_OK, 64'd0, 1'b0, 1'b0);
        add_row(sknr_pkg::REQ_PACKET, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0,
                sknr_pkg::ST_OK, 64'd0, 1'b0, 1'b0);
        foreach (table_q[i])
            send_word(table_q[i].word, table_q[i].typed, table_q[i].want);
        drain();

        // small limits so nonce cap, expiry and rate limit all fire often
        write_cfg(sknr_pkg::REG_REJECT_MSG, 64'($urandom_range(4, 40)));
        write_cfg(sknr_pkg::REG_REKEY_MSG, 64'($urandom_range(2, 30)));
        write_cfg(sknr_pkg::REG_REJECT_AGE, 64'd6000);
        write_cfg(sknr_pkg::REG_REKEY_AGE, 64'd3000);
        write_cfg(sknr_pkg::REG_HS_GAP, 64'd2000);
        wall_ticks = 64'd1000;
        run_random(110, 400);
        drain();

        // everything zero
        write_cfg(sknr_pkg::REG_REJECT_MSG, '0);
        write_cfg(sknr_pkg::REG_REKEY_MSG, '0);
        write_cfg(sknr_pkg::REG_REJECT_AGE, '0);
        write_cfg(sknr_pkg::REG_REKEY_AGE, '0);
        write_cfg(sknr_pkg::REG_HS_GAP, '0);
        run_random(60, 50);
        drain();

        // everything at its top; 32-bit registers drop the upper half
        write_cfg(sknr_pkg::REG_REJECT_MSG, '1);
        write_cfg(sknr_pkg::REG_REKEY_MSG, '1);
        write_cfg(sknr_pkg::REG_REJECT_AGE, '1);
        write_cfg(sknr_pkg::REG_REKEY_AGE, '1);
        write_cfg(sknr_pkg::REG_HS_GAP, '1);
        write_cfg(REG_UNMAPPED, '0);
        run_random(80, 32'h1000_0000);
        drain();

        // rekey on every packet, no handshake gap
        write_cfg(sknr_pkg::REG_REJECT_MSG, {$urandom, $urandom});
        write_cfg(sknr_pkg::REG_REKEY_MSG, '0);
        write_cfg(sknr_pkg::REG_REJECT_AGE,
                  {32'hA5A5_5A5A, 32'($urandom_range(1000, 5000))});
        write_cfg(sknr_pkg::REG_REKEY_AGE, '0);
        write_cfg(sknr_pkg::REG_HS_GAP, {32'h5A5A_A5A5, 32'd0});
        run_random(100, 200);
        drain();

        write_cfg(sknr_pkg::REG_REJECT_MSG, 64'($urandom_range(8, 60)));
        write_cfg(sknr_pkg::REG_REKEY_MSG, 64'($urandom_range(4, 40)));
        write_cfg(sknr_pkg::REG_REJECT_AGE, 64'd20000);
        write_cfg(sknr_pkg::REG_REKEY_AGE, 64'd8000);
        write_cfg(sknr_pkg::REG_HS_GAP, 64'd300);
        run_random(100, 600);
        drain();

        repeat (6) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
